[rtl/core/perspective_bary_depth_interp_core_assert.svh]
// Assertion macros shared by the checker of the interpolation core.
// Each macro expects clk and rst to be visible where it is used.
`ifndef PERSPECTIVE_BARY_DEPTH_INTERP_CORE_ASSERT_SVH
`define PERSPECTIVE_BARY_DEPTH_INTERP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define PBDI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define PBDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pbdi_pkg.sv]
// Shared types, limits and saturation helpers for the interpolation core.
// No dependencies.
package pbdi_pkg;

  localparam int ACC_W = 72;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [31:0]      q_t;
  typedef logic [16:0]             eps_t;

  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  // Byte address of the clamp epsilon register
  localparam logic [1:0] ADDR_EPSILON = 2'd0;

  // Saturate a wide signed value to the 32-bit range
  function automatic q_t sat32(acc_t x);
    if (x > acc_t'(Q_MAX)) return Q_MAX;
    if (x < acc_t'(Q_MIN)) return Q_MIN;
    return q_t'(x);
  endfunction

  // Push a value away from zero to at least eps, keeping its sign
  function automatic q_t eps_clamp(q_t x, eps_t eps);
    q_t e;
    e = signed'({15'b0, eps});
    if (!x[31]) return (x < e) ? e : x;
    return (x > -e) ? -e : x;
  endfunction

endpackage

[rtl/core/perspective_bary_depth_interp_core.sv]
// Perspective-correct barycentric interpolation core, one pixel per transaction.
// Depends on pbdi_pkg, pbdi_delay and pbdi_div.
//
// Accepts one pixel every clock while the output is not stalled, and returns
// its three perspective-correct weights and depth (Q16.16 by default) from
// two pipelined dividers in series, each FRAC_BITS + 34 stages deep (screen
// barycentrics and vertex inverse depths first, then the pixel depth). All
// stages advance together; while out_ready is low with a result waiting, the
// whole pipeline holds and in_ready is low.
// The clamp epsilon register sits at byte address 0 and must only be written
// while no pixel is in flight. Uncovered pixels give all-zero results.
module perspective_bary_depth_interp_core import pbdi_pkg::*; #(
  parameter int MAX_IMAGE_SIDE = 4096,
  parameter int FRAC_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] pixel_col,
  input  logic [11:0] pixel_row,
  input  logic        covered,
  input  q_t          vert0_x,
  input  q_t          vert0_y,
  input  q_t          vert0_z,
  input  q_t          vert1_x,
  input  q_t          vert1_y,
  input  q_t          vert1_z,
  input  q_t          vert2_x,
  input  q_t          vert2_y,
  input  q_t          vert2_z,
  output logic        out_valid,
  input  logic        out_ready,
  output q_t          weight0,
  output q_t          weight1,
  output q_t          weight2,
  output q_t          pixel_depth
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int L_DIV = NUM_W + 2;
  localparam int LAT   = 7 + 2 * L_DIV;
  localparam q_t ONE   = q_t'(1 << FRAC_BITS);
  localparam logic [NUM_W-1:0] DINV_NUM = {{(NUM_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);
  localparam logic [11:0] SIDE_MAX = (MAX_IMAGE_SIDE - 1 > 4095) ? 12'hfff
                                     : 12'(MAX_IMAGE_SIDE - 1);

  function automatic q_t qmul(q_t a, q_t b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(acc_t'(p) >>> FRAC_BITS);
  endfunction

  logic adv;
  eps_t eps;
  eps_t eps_eff;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = {15'b0, eps};

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= 17'd1;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_EPSILON) begin
      eps <= pwdata[16:0];
    end
  end

  assign eps_eff = (eps == '0) ? 17'd1 : eps;

  // Whole pipeline moves when the output slot is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: edges, pixel offsets, clamped vertex depths
  logic [11:0] col_c, row_c;
  q_t pos_x, pos_y;
  q_t e1x, e1y, e2x, e2y, dx, dy, zc0_1, zc1_1, zc2_1;

  assign col_c = (pixel_col > SIDE_MAX) ? SIDE_MAX : pixel_col;
  assign row_c = (pixel_row > SIDE_MAX) ? SIDE_MAX : pixel_row;
  assign pos_x = sat32(acc_t'({1'b0, col_c}) <<< FRAC_BITS);
  assign pos_y = sat32(acc_t'({1'b0, row_c}) <<< FRAC_BITS);

  always_ff @(posedge clk) begin
    if (adv) begin
      e1x   <= sat32(acc_t'(vert1_x) - acc_t'(vert0_x));
      e1y   <= sat32(acc_t'(vert1_y) - acc_t'(vert0_y));
      e2x   <= sat32(acc_t'(vert2_x) - acc_t'(vert0_x));
      e2y   <= sat32(acc_t'(vert2_y) - acc_t'(vert0_y));
      dx    <= sat32(acc_t'(pos_x) - acc_t'(vert0_x));
      dy    <= sat32(acc_t'(pos_y) - acc_t'(vert0_y));
      zc0_1 <= eps_clamp(vert0_z, eps_eff);
      zc1_1 <= eps_clamp(vert1_z, eps_eff);
      zc2_1 <= eps_clamp(vert2_z, eps_eff);
    end
  end

  // Stage 2: exact products
  logic signed [63:0] p_a, p_b, p_c, p_d, p_e, p_f;
  q_t zc0_2, zc1_2, zc2_2;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_a   <= e1x * e2y;
      p_b   <= e1y * e2x;
      p_c   <= dx * e2y;
      p_d   <= dy * e2x;
      p_e   <= dy * e1x;
      p_f   <= dx * e1y;
      zc0_2 <= zc0_1;
      zc1_2 <= zc1_1;
      zc2_2 <= zc2_1;
    end
  end

  // Stage 3: area and edge functions
  q_t area, pre1, pre2, zc0_3, zc1_3, zc2_3;

  always_ff @(posedge clk) begin
    if (adv) begin
      area  <= eps_clamp(sat32((acc_t'(p_a) - acc_t'(p_b)) >>> FRAC_BITS), eps_eff);
      pre1  <= sat32(acc_t'(sat32(acc_t'(p_c) >>> FRAC_BITS))
                   - acc_t'(sat32(acc_t'(p_d) >>> FRAC_BITS)));
      pre2  <= sat32(acc_t'(sat32(acc_t'(p_e) >>> FRAC_BITS))
                   - acc_t'(sat32(acc_t'(p_f) >>> FRAC_BITS)));
      zc0_3 <= zc0_2;
      zc1_3 <= zc1_2;
      zc2_3 <= zc2_2;
    end
  end

  // First divider bank: screen barycentrics and vertex inverse depths
  q_t b1q, b2q, dq0, dq1, dq2;

  pbdi_div #(.NUM_W(NUM_W)) u_div_b1 (
    .clk(clk), .en(adv), .num({pre1, {FRAC_BITS{1'b0}}}), .den(area), .quo(b1q));
  pbdi_div #(.NUM_W(NUM_W)) u_div_b2 (
    .clk(clk), .en(adv), .num({pre2, {FRAC_BITS{1'b0}}}), .den(area), .quo(b2q));
  pbdi_div #(.NUM_W(NUM_W)) u_div_z0 (
    .clk(clk), .en(adv), .num(DINV_NUM), .den(zc0_3), .quo(dq0));
  pbdi_div #(.NUM_W(NUM_W)) u_div_z1 (
    .clk(clk), .en(adv), .num(DINV_NUM), .den(zc1_3), .quo(dq1));
  pbdi_div #(.NUM_W(NUM_W)) u_div_z2 (
    .clk(clk), .en(adv), .num(DINV_NUM), .den(zc2_3), .quo(dq2));

  // Stage E: complete barycentric set
  q_t bary0, bary1, bary2, dinv0, dinv1, dinv2;

  always_ff @(posedge clk) begin
    if (adv) begin
      bary0 <= sat32(acc_t'(ONE) - acc_t'(b1q) - acc_t'(b2q));
      bary1 <= b1q;
      bary2 <= b2q;
      dinv0 <= dq0;
      dinv1 <= dq1;
      dinv2 <= dq2;
    end
  end

  // Stage F: weighted inverse depths
  q_t m0, m1, m2;

  always_ff @(posedge clk) begin
    if (adv) begin
      m0 <= qmul(dinv0, bary0);
      m1 <= qmul(dinv1, bary1);
      m2 <= qmul(dinv2, bary2);
    end
  end

  // Stage G: blended inverse depth, clamped
  q_t blend;

  always_ff @(posedge clk) begin
    if (adv) begin
      blend <= eps_clamp(sat32(acc_t'(m0) + acc_t'(m1) + acc_t'(m2)), eps_eff);
    end
  end

  // Second divider: pixel depth
  q_t depth;

  pbdi_div #(.NUM_W(NUM_W)) u_div_depth (
    .clk(clk), .en(adv), .num(DINV_NUM), .den(blend), .quo(depth));

  // Hold weighted inverse depths alongside the depth divider
  logic [95:0] m_d;

  pbdi_delay #(.W(96), .DEPTH(L_DIV + 1)) u_m_line (
    .clk(clk), .rst(rst), .en(adv), .din({m0, m1, m2}), .dout(m_d));

  // Coverage and valid travel with the pixel
  logic cov_d;

  pbdi_delay #(.W(1), .DEPTH(LAT - 1)) u_cov_line (
    .clk(clk), .rst(rst), .en(adv), .din(covered), .dout(cov_d));

  pbdi_delay #(.W(1), .DEPTH(LAT)) u_vld_line (
    .clk(clk), .rst(rst), .en(adv), .din(in_valid), .dout(out_valid));

  // Output stage: rescale weights, zero uncovered pixels
  always_ff @(posedge clk) begin
    if (adv) begin
      if (cov_d) begin
        weight0     <= qmul(q_t'(m_d[95:64]), depth);
        weight1     <= qmul(q_t'(m_d[63:32]), depth);
        weight2     <= qmul(q_t'(m_d[31:0]), depth);
        pixel_depth <= depth;
      end else begin
        weight0     <= '0;
        weight1     <= '0;
        weight2     <= '0;
        pixel_depth <= '0;
      end
    end
  end

endmodule

[rtl/core/pbdi_delay.sv]
// Enabled shift line that keeps data aligned with the pipeline stages.
// Depends on nothing.
module pbdi_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [DEPTH];

  // Advance the line when the pipeline moves
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) taps[k] <= '0;
    end else if (en) begin
      taps[0] <= din;
      for (int k = 1; k < DEPTH; k++) taps[k] <= taps[k-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

[rtl/core/pbdi_div.sv]
// Pipelined signed divider, one quotient bit per stage, saturated result.
// Depends on pbdi_pkg.
module pbdi_div import pbdi_pkg::*; #(
  parameter int NUM_W = 48
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  q_t                      den,
  output q_t                      quo
);

  logic [NUM_W-1:0] num_abs;
  logic [31:0]      den_abs;

  logic [31:0]      rem [NUM_W];
  logic [NUM_W-1:0] qn  [NUM_W+1];
  logic [31:0]      dv  [NUM_W];
  logic             sg  [NUM_W+1];

  logic [NUM_W-1:0] q_fin;

  // Take magnitudes, keep the result sign
  assign num_abs = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign den_abs = den[31] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      qn[0]  <= num_abs;
      dv[0]  <= den_abs;
      sg[0]  <= num[NUM_W-1] ^ den[31];
    end
  end

  // Restoring steps: shift in one dividend bit, subtract when it fits
  for (genvar k = 1; k <= NUM_W; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem[k-1], qn[k-1][NUM_W-1]};
    assign ge    = trial >= {1'b0, dv[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        qn[k]  <= {qn[k-1][NUM_W-2:0], ge};
        sg[k]  <= sg[k-1];
      end
    end
    // Carry remainder and divisor to the next step
    if (k < NUM_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? 32'(trial - {1'b0, dv[k-1]}) : trial[31:0];
          dv[k]  <= dv[k-1];
        end
      end
    end
  end

  assign q_fin = qn[NUM_W];

  // Apply sign and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      if (sg[NUM_W]) begin
        if (q_fin > {{(NUM_W-32){1'b0}}, 32'h8000_0000}) quo <= Q_MIN;
        else quo <= -q_t'(q_fin[31:0]);
      end else begin
        if (q_fin > {{(NUM_W-32){1'b0}}, 32'h7fff_ffff}) quo <= Q_MAX;
        else quo <= q_t'(q_fin[31:0]);
      end
    end
  end

endmodule

[rtl/core/pbdi_checker.sv]
// Port-level checks for the interpolation core, bound to the top level.
// Depends on pbdi_pkg and the assertion macro header.
`include "perspective_bary_depth_interp_core_assert.svh"

module pbdi_checker import pbdi_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready,
  input logic [1:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input q_t          weight0,
  input q_t          weight1,
  input q_t          weight2,
  input q_t          pixel_depth
);

  // Input side takes a transaction exactly when the output slot moves
  `PBDI_ASSERT_IMPL(a_ready_follows_output, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not track the output slot")

  // A written epsilon reads back on the next cycle
  `PBDI_ASSERT_NEXT(a_eps_readback, psel && penable && pwrite && pready && paddr == ADDR_EPSILON, prdata == {15'b0, $past(pwdata[16:0])}, "epsilon readback mismatch")

  // Nothing comes out right after reset
  `PBDI_ASSERT_IMPL(a_empty_after_reset, $past(rst), !out_valid, "result valid right after reset")

  // A stalled result holds
  `PBDI_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(weight0) && $stable(weight1) && $stable(weight2) && $stable(pixel_depth), "stalled result changed")

endmodule

bind perspective_bary_depth_interp_core pbdi_checker u_pbdi_checker (.*);

[test/tb_perspective_bary_depth_interp_core.sv]
// Testbench for perspective_bary_depth_interp_core: directed and random pixels checked
// against a fixed-point predictor of weights and depth, over several epsilon settings.
// Depends on pbdi_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_perspective_bary_depth_interp_core;
  import pbdi_pkg::*;

  localparam int FRAC      = 16;
  localparam int SETTLE    = 130;   // pipeline latency plus margin
  localparam int STALL_MAX = 3000;  // cycles without any transaction

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic        cov;
    q_t          x[3];
    q_t          y[3];
    q_t          z[3];
  } pixel_t;

  typedef struct {
    q_t w[3];
    q_t depth;
  } interp_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready, out_valid, out_ready;
  q_t          weight0, weight1, weight2, pixel_depth;
  pixel_t      drv;

  interp_t     pixel_expect[$];
  eps_t        eps_shadow;
  int          errors;
  int          idle_cycles;
  bit          idle_en;
  bit          hold_req;

  perspective_bary_depth_interp_core u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_col(drv.col), .pixel_row(drv.row), .covered(drv.cov),
    .vert0_x(drv.x[0]), .vert0_y(drv.y[0]), .vert0_z(drv.z[0]),
    .vert1_x(drv.x[1]), .vert1_y(drv.y[1]), .vert1_z(drv.z[1]),
    .vert2_x(drv.x[2]), .vert2_y(drv.y[2]), .vert2_z(drv.z[2]),
    .out_valid(out_valid), .out_ready(out_ready),
    .weight0(weight0), .weight1(weight1), .weight2(weight2), .pixel_depth(pixel_depth)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat_q((a * b) >>> FRAC);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    return sat_q((a * (64'sd1 <<< FRAC)) / b);
  endfunction

  function automatic longint push_off_zero(longint v, longint eps);
    if (v >= 0) return (v < eps) ? eps : v;
    return (v > -eps) ? -eps : v;
  endfunction

  function automatic interp_t predict_pixel(pixel_t p, eps_t eps_reg);
    interp_t r;
    longint  unit, eps, e1x, e1y, e2x, e2y, area, dx, dy, pre1, pre2;
    longint  blend, depth;
    longint  vx[3], vy[3], inv_z[3], bary[3];
    unit = 64'sd1 <<< FRAC;
    eps  = (eps_reg == 0) ? 1 : longint'(eps_reg);
    if (!p.cov) begin
      r.w[0] = '0; r.w[1] = '0; r.w[2] = '0; r.depth = '0;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      vx[i] = longint'(p.x[i]);
      vy[i] = longint'(p.y[i]);
      inv_z[i] = fx_div(unit, push_off_zero(longint'(p.z[i]), eps));
    end
    e1x  = sat_q(vx[1] - vx[0]);
    e1y  = sat_q(vy[1] - vy[0]);
    e2x  = sat_q(vx[2] - vx[0]);
    e2y  = sat_q(vy[2] - vy[0]);
    area = push_off_zero(sat_q((e1x * e2y - e1y * e2x) >>> FRAC), eps);
    // 12-bit coordinates never exceed the image side, so no clamp is needed
    dx   = sat_q((longint'(p.col) <<< FRAC) - vx[0]);
    dy   = sat_q((longint'(p.row) <<< FRAC) - vy[0]);
    pre1 = sat_q(fx_mul(dx, e2y) - fx_mul(dy, e2x));
    pre2 = sat_q(fx_mul(dy, e1x) - fx_mul(dx, e1y));
    bary[1] = fx_div(pre1, area);
    bary[2] = fx_div(pre2, area);
    bary[0] = sat_q(unit - bary[1] - bary[2]);
    blend = sat_q(fx_mul(inv_z[0], bary[0]) + fx_mul(inv_z[1], bary[1]) +
                  fx_mul(inv_z[2], bary[2]));
    depth = fx_div(unit, push_off_zero(blend, eps));
    for (int i = 0; i < 3; i++) r.w[i] = q_t'(fx_mul(fx_mul(inv_z[i], bary[i]), depth));
    r.depth = q_t'(depth);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input q_t got, input q_t want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    interp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixel_expect.size() == 0) begin
        report_mismatch("unexpected result transaction", weight0, '0);
      end else begin
        want = pixel_expect.pop_front();
        if (weight0 !== want.w[0]) report_mismatch("weight0", weight0, want.w[0]);
        if (weight1 !== want.w[1]) report_mismatch("weight1", weight1, want.w[1]);
        if (weight2 !== want.w[2]) report_mismatch("weight2", weight2, want.w[2]);
        if (pixel_depth !== want.depth) report_mismatch("pixel_depth", pixel_depth, want.depth);
      end
    end
  end

  // Watchdog: count cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("[perspective_bary_depth_interp_core] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Hold valid and payload until accepted, then record the expectation
  task automatic send_pixel(input pixel_t p);
    drv      <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pixel_expect.push_back(predict_pixel(p, eps_shadow));
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pixel_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup and access cycle, then read back
  task automatic write_epsilon(input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_EPSILON; pwdata <= value; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    eps_shadow = value[16:0];
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[16:0] !== eps_shadow)
      report_mismatch("epsilon readback", prdata, {15'b0, eps_shadow});
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic q_t edge_value();
    case ($urandom_range(0, 6))
      0: return 32'sh0000_0000;
      1: return 32'sh0000_0001;
      2: return -32'sd1;
      3: return Q_MAX;
      4: return Q_MIN;
      5: return 32'sh0001_0000;
      default: return -32'sh0001_0000;
    endcase
  endfunction

  // Mostly plausible triangles around the pixel, some noise and extremes
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     mode;
    mode  = $urandom_range(0, 9);
    p.col = 12'($urandom);
    p.row = 12'($urandom);
    p.cov = ($urandom_range(0, 7) != 0);
    for (int i = 0; i < 3; i++) begin
      if (mode <= 6) begin
        p.x[i] = (int'(p.col) <<< 16) + ($urandom_range(0, 128 << 16) - (64 << 16));
        p.y[i] = (int'(p.row) <<< 16) + ($urandom_range(0, 128 << 16) - (64 << 16));
        p.z[i] = ($urandom_range(0, 9) == 0) ? q_t'($urandom_range(0, 512) - 256)
                                            : q_t'($urandom_range(1 << 12, 64 << 16));
      end else if (mode <= 8) begin
        p.x[i] = $urandom; p.y[i] = $urandom; p.z[i] = $urandom;
      end else begin
        p.x[i] = edge_value(); p.y[i] = edge_value(); p.z[i] = edge_value();
      end
    end
    return p;
  endfunction

  function automatic pixel_t tri_pixel(int col, int row, q_t x0, q_t y0, q_t x1, q_t y1,
                                       q_t x2, q_t y2, q_t z0, q_t z1, q_t z2);
    pixel_t p;
    p.col = 12'(col); p.row = 12'(row); p.cov = 1'b1;
    p.x[0] = x0; p.y[0] = y0; p.z[0] = z0;
    p.x[1] = x1; p.y[1] = y1; p.z[1] = z1;
    p.x[2] = x2; p.y[2] = y2; p.z[2] = z2;
    return p;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    pixel_t p;
    q_t     one;
    one = 32'sh0001_0000;
    // plain triangle, pixel inside
    send_pixel(tri_pixel(2, 2, 0, 0, 8 * one, 0, 0, 8 * one, one, 2 * one, 4 * one));
    // uncovered pixel with garbage vertices
    p = rand_pixel(); p.cov = 1'b0; send_pixel(p);
    p.x[0] = Q_MAX; p.z[1] = 0; send_pixel(p);
    // zero area: collapsed triangle
    send_pixel(tri_pixel(5, 5, 5 * one, 5 * one, 5 * one, 5 * one, 5 * one, 5 * one,
                         one, one, one));
    // zero and negative depths, and a depth below epsilon
    send_pixel(tri_pixel(1, 1, 0, 0, 4 * one, 0, 0, 4 * one, 0, -one, 1));
    send_pixel(tri_pixel(1, 1, 0, 0, 4 * one, 0, 0, 4 * one, -one, -2 * one, -1));
    // blended inverse depth near zero: opposite-sign depths
    send_pixel(tri_pixel(1, 1, 0, 0, 2 * one, 0, 0, 2 * one, one, -one, one));
    // pixel far outside, coordinate extremes
    send_pixel(tri_pixel(4095, 4095, 0, 0, one, 0, 0, one, one, one, one));
    send_pixel(tri_pixel(0, 0, 4095 * one, 4095 * one, 4094 * one, 4095 * one,
                         4095 * one, 4094 * one, one, one, one));
    // vertex extremes: saturating edges and area
    send_pixel(tri_pixel(0, 4095, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX,
                         Q_MAX, Q_MAX, Q_MAX));
    send_pixel(tri_pixel(4095, 0, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN,
                         Q_MIN, Q_MIN, Q_MIN));
    send_pixel(tri_pixel(0, 0, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 0, 0, 1, Q_MAX, Q_MIN));
    // clockwise (negative area) and tiny area
    send_pixel(tri_pixel(3, 3, 0, 0, 0, 8 * one, 8 * one, 0, 2 * one, 3 * one, one));
    send_pixel(tri_pixel(0, 0, 0, 0, 1, 0, 0, 1, one, one, one));
    for (int i = 0; i < 8; i++) begin
      p = rand_pixel(); p.cov = 1'b1;
      for (int k = 0; k < 3; k++) begin
        p.x[k] = edge_value(); p.y[k] = edge_value(); p.z[k] = edge_value();
      end
      send_pixel(p);
    end
    drain_and_settle();
  endtask

  task automatic test_epsilon_sweep();
    logic [31:0] settings[5];
    settings = '{32'h0001_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001,
                 32'h0000_0000};
    settings[4] = $urandom_range(1, 65536);
    foreach (settings[s]) begin
      write_epsilon(settings[s]);
      repeat (40) send_pixel(rand_pixel());
      drain_and_settle();
    end
  endtask

  // Long result stall while pixels keep coming: the pipeline must fill and hold
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (180) send_pixel(rand_pixel());
    drain_and_settle();
  endtask

  task automatic test_full_rate();
    write_epsilon($urandom_range(1, 256));
    idle_en = 1'b0;
    repeat (100) send_pixel(rand_pixel());
    drain_and_settle();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    drv = rand_pixel();
    eps_shadow = 17'd1;
    errors = 0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_epsilon_sweep();
    test_backpressure();
    test_full_rate();
    if (errors == 0)
      $display("[perspective_bary_depth_interp_core] OK");
    else
      $display("[perspective_bary_depth_interp_core] ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/pbdi_pkg.sv
rtl/core/pbdi_delay.sv
rtl/core/pbdi_div.sv
rtl/core/perspective_bary_depth_interp_core.sv
rtl/core/pbdi_checker.sv
test/tb_perspective_bary_depth_interp_core.sv
